/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by srsg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define SRSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising clk edge, reset included.
`define SRSG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/srsg_pkg.sv */
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared widths, codes and types of the stepper step generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

    localparam int SPEED_W    = 16;
    localparam int ACCEL_W    = 15;
    localparam int DIVIDEND_W = 32;
    localparam int ZSP_W      = 16;
    localparam int DIR_W      = 2;
    localparam int POS_W      = 32;
    localparam int OUT_PER_W  = 16;
    localparam int PULSE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MOTOR_COUNT_DEF = 2;
    localparam int PERIOD_BITS_DEF = 16;

    localparam logic [ACCEL_W-1:0]    MAX_ACCEL_RST     = 15'd8;
    localparam logic [DIVIDEND_W-1:0] RPM_TO_PERIOD_RST = 32'd37500;
    localparam logic [ZSP_W-1:0]      ZSP_RST           = 16'd65535;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_TO_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPEED    = 2'd2;

    typedef struct packed {
        logic tick;
        logic wr;
    } bank_ctl_t;

endpackage

/* hdl/srsg_div.sv */
// ----------------------------------------------------------------------------
// srsg_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srsg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srsg_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [srsg_pkg::SPEED_W-1:0]      divisor,
    output logic                              done,
    output logic [srsg_pkg::DIVIDEND_W-1:0]   quotient
);
    import srsg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SPEED_W-1:0]      divisor_reg, divisor_next;
    logic [SPEED_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0]   quot_reg, quot_next;

    logic [SPEED_W:0]        trial;
    logic [SPEED_W+1:0]      diff;
    logic                    ge;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff  = {1'b0, trial} - {2'b00, divisor_reg};
        ge    = !diff[SPEED_W+1];

        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            divisor_next = divisor;
            rem_next     = '0;
            quot_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
            quot_next  = {quot_reg[DIVIDEND_W-2:0], ge};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* hdl/srsg_motors.sv */
// ----------------------------------------------------------------------------
// srsg_motors
// Per-motor state: speed, period, direction, pin, CTC counter, position.
// ----------------------------------------------------------------------------
module srsg_motors #(
    parameter int MOTOR_COUNT = srsg_pkg::MOTOR_COUNT_DEF,
    parameter int PERIOD_BITS = srsg_pkg::PERIOD_BITS_DEF,
    parameter int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srsg_pkg::bank_ctl_t                 ctl,
    input  logic [MIDX_W-1:0]                   sel,
    input  logic signed [srsg_pkg::SPEED_W-1:0] wr_speed,
    input  logic [PERIOD_BITS-1:0]              wr_period,
    input  logic [srsg_pkg::DIR_W-1:0]          wr_dir,
    output logic signed [srsg_pkg::SPEED_W-1:0] rd_speed,
    output logic [PERIOD_BITS-1:0]              rd_period,
    output logic [srsg_pkg::DIR_W-1:0]          rd_dir,
    output logic                                rd_level,
    output logic [srsg_pkg::PULSE_W-1:0]        pulses,
    output logic [srsg_pkg::POS_W-1:0]          pos_first,
    output logic [srsg_pkg::POS_W-1:0]          pos_second
);
    import srsg_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg  [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] speed_next [MOTOR_COUNT];
    logic [PERIOD_BITS-1:0]    period_reg [MOTOR_COUNT];
    logic [PERIOD_BITS-1:0]    period_next[MOTOR_COUNT];
    logic [DIR_W-1:0]          dir_reg    [MOTOR_COUNT];
    logic [DIR_W-1:0]          dir_next   [MOTOR_COUNT];
    logic                      level_reg  [MOTOR_COUNT];
    logic                      level_next [MOTOR_COUNT];
    logic [PERIOD_BITS-1:0]    cnt_reg    [MOTOR_COUNT];
    logic [PERIOD_BITS-1:0]    cnt_next   [MOTOR_COUNT];
    logic [POS_W-1:0]          pos_reg    [MOTOR_COUNT];
    logic [POS_W-1:0]          pos_next   [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]    step_hit;

    always_comb
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            speed_next[m]  = speed_reg[m];
            period_next[m] = period_reg[m];
            dir_next[m]    = dir_reg[m];
            level_next[m]  = level_reg[m];
            cnt_next[m]    = cnt_reg[m];
            pos_next[m]    = pos_reg[m];
            step_hit[m]    = (cnt_reg[m] == period_reg[m]) && (dir_reg[m] != DIR_STOP);

            if (ctl.tick)
            begin
                if (cnt_reg[m] == period_reg[m])
                begin
                    cnt_next[m] = '0;
                    if (dir_reg[m] == DIR_FWD)
                        pos_next[m] = pos_reg[m] + 1'b1;
                    else if (dir_reg[m] == DIR_REV)
                        pos_next[m] = pos_reg[m] - 1'b1;
                end
                else
                begin
                    cnt_next[m] = cnt_reg[m] + 1'b1;
                end
            end

            if (ctl.wr && (sel == MIDX_W'(m)))
            begin
                speed_next[m]  = wr_speed;
                period_next[m] = wr_period;
                dir_next[m]    = wr_dir;
                // odd motors drive the pin mirrored
                if (wr_dir != DIR_STOP)
                    level_next[m] = (wr_dir == DIR_FWD) ^ 1'(m);
                if (cnt_reg[m] > wr_period)
                    cnt_next[m] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                speed_reg[m]  <= '0;
                period_reg[m] <= PERIOD_BITS'(ZSP_RST);
                dir_reg[m]    <= DIR_STOP;
                level_reg[m]  <= 1'b0;
                cnt_reg[m]    <= '0;
                pos_reg[m]    <= '0;
            end
        end
        else
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                speed_reg[m]  <= speed_next[m];
                period_reg[m] <= period_next[m];
                dir_reg[m]    <= dir_next[m];
                level_reg[m]  <= level_next[m];
                cnt_reg[m]    <= cnt_next[m];
                pos_reg[m]    <= pos_next[m];
            end
        end
    end

    assign rd_speed  = speed_reg[sel];
    assign rd_period = period_reg[sel];
    assign rd_dir    = dir_reg[sel];
    assign rd_level  = level_reg[sel];
    assign pos_first = pos_reg[0];
    assign pulses[0] = step_hit[0];

    generate
        if (MOTOR_COUNT > 1)
        begin : g_second
            assign pos_second = pos_reg[1];
            assign pulses[1]  = step_hit[1];
        end
        else
        begin : g_single
            assign pos_second = '0;
            assign pulses[1]  = 1'b0;
        end
    endgenerate

endmodule

/* hdl/stepper_ramp_step_generator_core.sv */
// Tick word: accepted in ST_IDLE; ST_FINISH loads the result registers, then ST_IDLE.
// Speed word: ST_RAMP, ST_DIVIDE (divider), ST_WRITE (state write), ST_FINISH (result
// load), then ST_IDLE; a ramped speed of zero skips the divider (ST_RAMP to ST_WRITE).
// A stalled result holds the sequencer in ST_FINISH; in_ready is high only when idle.
// Async reset (rst_n low): registers at documented defaults, all motors stopped.
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_core
// Two-motor step generator with per-command acceleration limit.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator_core #(
    parameter int MOTOR_COUNT = srsg_pkg::MOTOR_COUNT_DEF,
    parameter int PERIOD_BITS = srsg_pkg::PERIOD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic                                  motor,
    input  logic signed [srsg_pkg::SPEED_W-1:0]   rpm_target,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [srsg_pkg::SPEED_W-1:0]   ramped_speed,
    output logic [srsg_pkg::OUT_PER_W-1:0]        compare_period,
    output logic [srsg_pkg::DIR_W-1:0]            motion_dir,
    output logic                                  dir_pin,
    output logic [srsg_pkg::PULSE_W-1:0]          step_pulses,
    output logic signed [srsg_pkg::POS_W-1:0]     position_first,
    output logic signed [srsg_pkg::POS_W-1:0]     position_second,
    input  logic                                  cfg_wr_en,
    input  logic [srsg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [srsg_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import srsg_pkg::*;

    localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic [DIVIDEND_W:0] PERIOD_MAX =
        (DIVIDEND_W+1)'((64'd1 << PERIOD_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_DIVIDE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // configuration
    logic [ACCEL_W-1:0]    max_accel_reg;
    logic [DIVIDEND_W-1:0] rpm_to_period_reg;
    logic [ZSP_W-1:0]      zsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg     <= MAX_ACCEL_RST;
            rpm_to_period_reg <= RPM_TO_PERIOD_RST;
            zsp_reg           <= ZSP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAX_ACCEL:     max_accel_reg     <= cfg_data[ACCEL_W-1:0];
                REG_RPM_TO_PERIOD: rpm_to_period_reg <= cfg_data[DIVIDEND_W-1:0];
                REG_ZERO_SPEED:    zsp_reg           <= cfg_data[ZSP_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer and result registers
    state_t                    state_reg, state_next;
    logic [MIDX_W-1:0]         sel_reg, sel_next;
    logic signed [SPEED_W-1:0] target_reg, target_next;
    logic signed [SPEED_W-1:0] speed_new_reg, speed_new_next;
    logic [PULSE_W-1:0]        pulses_reg, pulses_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0] ramped_speed_reg, ramped_speed_next;
    logic [OUT_PER_W-1:0]      compare_period_reg, compare_period_next;
    logic [DIR_W-1:0]          motion_dir_reg, motion_dir_next;
    logic                      dir_pin_reg, dir_pin_next;
    logic [PULSE_W-1:0]        step_pulses_reg, step_pulses_next;
    logic [POS_W-1:0]          pos_first_reg, pos_first_next;
    logic [POS_W-1:0]          pos_second_reg, pos_second_next;

    bank_ctl_t                 bank_ctl;
    logic signed [SPEED_W-1:0] rd_speed;
    logic [PERIOD_BITS-1:0]    rd_period;
    logic [DIR_W-1:0]          rd_dir;
    logic                      rd_level;
    logic [PULSE_W-1:0]        bank_pulses;
    logic [POS_W-1:0]          bank_pos_first;
    logic [POS_W-1:0]          bank_pos_second;
    logic [PERIOD_BITS-1:0]    wr_period;
    logic [DIR_W-1:0]          wr_dir;

    logic                      div_start;
    logic                      div_done;
    logic [DIVIDEND_W-1:0]     quotient;

    logic                      accept;
    logic                      motor_ok;
    logic signed [SPEED_W:0]   diff_c;
    logic signed [SPEED_W:0]   acc_c;
    logic signed [SPEED_W:0]   speed_ext;
    logic signed [SPEED_W-1:0] speed_ramp_c;
    logic [SPEED_W-1:0]        mag_c;
    logic                      period_ovf;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_ready = (state_reg == ST_IDLE);
    assign motor_ok = (32'(motor) < 32'(MOTOR_COUNT));

    // acceleration limit
    always_comb
    begin
        speed_ext = {rd_speed[SPEED_W-1], rd_speed};
        acc_c     = signed'({2'b00, max_accel_reg});
        diff_c    = speed_ext - {target_reg[SPEED_W-1], target_reg};
        if (diff_c > acc_c)
            speed_ramp_c = SPEED_W'(speed_ext - acc_c);
        else if (diff_c < -acc_c)
            speed_ramp_c = SPEED_W'(speed_ext + acc_c);
        else
            speed_ramp_c = target_reg;
        mag_c = speed_ramp_c[SPEED_W-1] ? SPEED_W'(-speed_ramp_c) : speed_ramp_c;
    end

    assign div_start  = (state_reg == ST_RAMP) && (speed_ramp_c != '0);
    assign period_ovf = {1'b0, quotient} > PERIOD_MAX;

    always_comb
    begin
        if (speed_new_reg == '0)
        begin
            wr_dir    = DIR_STOP;
            wr_period = PERIOD_BITS'(zsp_reg);
        end
        else
        begin
            wr_dir    = speed_new_reg[SPEED_W-1] ? DIR_REV : DIR_FWD;
            wr_period = period_ovf ? PERIOD_BITS'(zsp_reg) : quotient[PERIOD_BITS-1:0];
        end
    end

    assign bank_ctl.tick = accept && (action == ACT_TICK);
    assign bank_ctl.wr   = (state_reg == ST_WRITE);

    always_comb
    begin
        state_next          = state_reg;
        sel_next            = sel_reg;
        target_next         = target_reg;
        speed_new_next      = speed_new_reg;
        pulses_next         = pulses_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        ramped_speed_next   = ramped_speed_reg;
        compare_period_next = compare_period_reg;
        motion_dir_next     = motion_dir_reg;
        dir_pin_next        = dir_pin_reg;
        step_pulses_next    = step_pulses_reg;
        pos_first_next      = pos_first_reg;
        pos_second_next     = pos_second_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sel_next    = motor_ok ? MIDX_W'(motor) : '0;
                    target_next = rpm_target;
                    pulses_next = (action == ACT_TICK) ? bank_pulses : '0;
                    if (action == ACT_SET && motor_ok)
                        state_next = ST_RAMP;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_RAMP:
            begin
                speed_new_next = speed_ramp_c;
                state_next     = div_start ? ST_DIVIDE : ST_WRITE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    ramped_speed_next   = rd_speed;
                    compare_period_next = OUT_PER_W'(rd_period);
                    motion_dir_next     = rd_dir;
                    dir_pin_next        = rd_level;
                    step_pulses_next    = pulses_reg;
                    pos_first_next      = bank_pos_first;
                    pos_second_next     = bank_pos_second;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            sel_reg            <= '0;
            target_reg         <= '0;
            speed_new_reg      <= '0;
            pulses_reg         <= '0;
            out_valid_reg      <= 1'b0;
            ramped_speed_reg   <= '0;
            compare_period_reg <= '0;
            motion_dir_reg     <= DIR_STOP;
            dir_pin_reg        <= 1'b0;
            step_pulses_reg    <= '0;
            pos_first_reg      <= '0;
            pos_second_reg     <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            sel_reg            <= sel_next;
            target_reg         <= target_next;
            speed_new_reg      <= speed_new_next;
            pulses_reg         <= pulses_next;
            out_valid_reg      <= out_valid_next;
            ramped_speed_reg   <= ramped_speed_next;
            compare_period_reg <= compare_period_next;
            motion_dir_reg     <= motion_dir_next;
            dir_pin_reg        <= dir_pin_next;
            step_pulses_reg    <= step_pulses_next;
            pos_first_reg      <= pos_first_next;
            pos_second_reg     <= pos_second_next;
        end
    end

    srsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rpm_to_period_reg),
        .divisor  (mag_c),
        .done     (div_done),
        .quotient (quotient)
    );

    srsg_motors #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .PERIOD_BITS (PERIOD_BITS),
        .MIDX_W      (MIDX_W)
    ) u_motors (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bank_ctl),
        .sel        (sel_reg),
        .wr_speed   (speed_new_reg),
        .wr_period  (wr_period),
        .wr_dir     (wr_dir),
        .rd_speed   (rd_speed),
        .rd_period  (rd_period),
        .rd_dir     (rd_dir),
        .rd_level   (rd_level),
        .pulses     (bank_pulses),
        .pos_first  (bank_pos_first),
        .pos_second (bank_pos_second)
    );

    assign out_valid       = out_valid_reg;
    assign ramped_speed    = ramped_speed_reg;
    assign compare_period  = compare_period_reg;
    assign motion_dir      = motion_dir_reg;
    assign dir_pin         = dir_pin_reg;
    assign step_pulses     = step_pulses_reg;
    assign position_first  = pos_first_reg;
    assign position_second = pos_second_reg;

endmodule

/* hdl/srsg_checker.sv */
// ----------------------------------------------------------------------------
// srsg_checker
// Port-level checks of the step generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srsg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [srsg_pkg::SPEED_W-1:0]   ramped_speed,
    input logic [srsg_pkg::OUT_PER_W-1:0]        compare_period,
    input logic [srsg_pkg::DIR_W-1:0]            motion_dir,
    input logic                                  dir_pin,
    input logic [srsg_pkg::PULSE_W-1:0]          step_pulses,
    input logic signed [srsg_pkg::POS_W-1:0]     position_first,
    input logic signed [srsg_pkg::POS_W-1:0]     position_second
);
    import srsg_pkg::*;

    // stalled result word holds
    `SRSG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(ramped_speed) && $stable(compare_period) && $stable(motion_dir) && $stable(dir_pin) && $stable(step_pulses) && $stable(position_first) && $stable(position_second), "result word changed while stalled")
    `SRSG_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "word accepted on back-to-back cycles")
    `SRSG_ASSERT(a_stop_zero, out_valid |-> ((motion_dir == DIR_STOP) == (ramped_speed == 16'sd0)), "stopped direction disagrees with speed")
    `SRSG_ASSERT(a_fwd_positive, out_valid && (motion_dir == DIR_FWD) |-> (ramped_speed > 16'sd0), "forward direction with non-positive speed")
    `SRSG_ASSERT_RST(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind stepper_ramp_step_generator_core srsg_checker u_srsg_checker (.*);

/* tb/step_rate_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_rate_checker
// Watches the word, config and report channels of the step generator, keeps
// its own copy of both motors' ramp, period, counter and position state, and
// compares each report word with the oldest predicted one.
// ----------------------------------------------------------------------------
module step_rate_checker
    import srsg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         action,
    input  logic                         motor,
    input  logic signed [SPEED_W-1:0]    rpm_target,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [SPEED_W-1:0]    ramped_speed,
    input  logic [OUT_PER_W-1:0]         compare_period,
    input  logic [DIR_W-1:0]             motion_dir,
    input  logic                         dir_pin,
    input  logic [PULSE_W-1:0]           step_pulses,
    input  logic signed [POS_W-1:0]      position_first,
    input  logic signed [POS_W-1:0]      position_second,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           fail_count,
    output int                           pending
);

    localparam int NUM_MOTORS = MOTOR_COUNT_DEF;
    localparam longint unsigned PERIOD_TOP = (64'd1 << OUT_PER_W) - 1;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [OUT_PER_W-1:0]      period;
        logic [DIR_W-1:0]          heading;
        logic                      pin;
        logic [PULSE_W-1:0]        pulses;
        logic signed [POS_W-1:0]   pos0;
        logic signed [POS_W-1:0]   pos1;
    } motor_report_t;

    logic [ACCEL_W-1:0]        accel_lim;
    logic [DIVIDEND_W-1:0]     rpm_div;
    logic [ZSP_W-1:0]          stop_period;

    logic signed [SPEED_W-1:0] spd     [NUM_MOTORS];
    logic [OUT_PER_W-1:0]      per_now [NUM_MOTORS];
    logic [DIR_W-1:0]          heading [NUM_MOTORS];
    logic                      lvl     [NUM_MOTORS];
    logic [OUT_PER_W-1:0]      cnt     [NUM_MOTORS];
    logic signed [POS_W-1:0]   pos     [NUM_MOTORS];

    motor_report_t reports_due[$];

    task automatic ramp_motor(input int m, input logic signed [SPEED_W-1:0] tgt);
        int acc;
        int t;
        int cur;
        int nxt;
        int mag;
        longint unsigned dividend;
        longint unsigned divisor;
        longint unsigned quo;
        logic [OUT_PER_W-1:0] per;
        acc = int'(accel_lim);
        t = int'(tgt);
        cur = int'(spd[m]);
        if (cur - t > acc)
            nxt = cur - acc;
        else if (cur - t < -acc)
            nxt = cur + acc;
        else
            nxt = t;
        spd[m] = nxt[SPEED_W-1:0];
        if (nxt == 0)
        begin
            per = stop_period;
            heading[m] = DIR_STOP;
        end
        else
        begin
            mag = (nxt > 0) ? nxt : -nxt;
            dividend = 64'(rpm_div);
            divisor = 64'(mag);
            quo = dividend / divisor;
            per = (quo > PERIOD_TOP) ? stop_period : quo[OUT_PER_W-1:0];
            if (nxt > 0)
            begin
                heading[m] = DIR_FWD;
                lvl[m] = (m % 2 == 1) ? 1'b0 : 1'b1;
            end
            else
            begin
                heading[m] = DIR_REV;
                lvl[m] = (m % 2 == 1) ? 1'b1 : 1'b0;
            end
        end
        per_now[m] = per;
        if (cnt[m] > per_now[m])
            cnt[m] = '0;
    endtask

    task automatic predict_report(input logic act, input logic mot,
                                  input logic signed [SPEED_W-1:0] tgt,
                                  output motor_report_t rep);
        logic [PULSE_W-1:0] fired;
        int r;
        fired = '0;
        if (act == ACT_SET)
        begin
            ramp_motor(int'(mot), tgt);
        end
        else
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                if (cnt[m] == per_now[m])
                begin
                    cnt[m] = '0;
                    if (heading[m] != DIR_STOP)
                    begin
                        fired[m] = 1'b1;
                        if (heading[m] == DIR_FWD)
                            pos[m] = pos[m] + 1;
                        else
                            pos[m] = pos[m] - 1;
                    end
                end
                else
                begin
                    cnt[m] = cnt[m] + 1'b1;
                end
            end
        end
        r = int'(mot);
        rep.speed   = spd[r];
        rep.period  = per_now[r];
        rep.heading = heading[r];
        rep.pin     = lvl[r];
        rep.pulses  = fired;
        rep.pos0    = pos[0];
        rep.pos1    = pos[1];
    endtask

    task automatic note_failure(input string what, input motor_report_t exp_r,
                                input motor_report_t got_r);
        fail_count++;
        if (fail_count <= 10)
        begin
            $write("%0t %s: exp spd %0d per %0d dir %0d pin %0b stp %b pos %0d/%0d",
                   $realtime, what,
                   exp_r.speed, exp_r.period, exp_r.heading, exp_r.pin, exp_r.pulses,
                   exp_r.pos0, exp_r.pos1);
            $display(" | got spd %0d per %0d dir %0d pin %0b stp %b pos %0d/%0d",
                     got_r.speed, got_r.period, got_r.heading, got_r.pin, got_r.pulses,
                     got_r.pos0, got_r.pos1);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        motor_report_t got_r;
        motor_report_t exp_r;
        if (!rst_n)
        begin
            accel_lim   = MAX_ACCEL_RST;
            rpm_div     = RPM_TO_PERIOD_RST;
            stop_period = ZSP_RST;
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                spd[m]     = '0;
                per_now[m] = ZSP_RST;
                heading[m] = DIR_STOP;
                lvl[m]     = 1'b0;
                cnt[m]     = '0;
                pos[m]     = '0;
            end
            reports_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MAX_ACCEL:     accel_lim   = cfg_data[ACCEL_W-1:0];
                    REG_RPM_TO_PERIOD: rpm_div     = cfg_data[DIVIDEND_W-1:0];
                    REG_ZERO_SPEED:    stop_period = cfg_data[ZSP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got_r.speed   = ramped_speed;
                got_r.period  = compare_period;
                got_r.heading = motion_dir;
                got_r.pin     = dir_pin;
                got_r.pulses  = step_pulses;
                got_r.pos0    = position_first;
                got_r.pos1    = position_second;
                if (reports_due.size() == 0)
                begin
                    exp_r = '0;
                    note_failure("unexpected word", exp_r, got_r);
                end
                else
                begin
                    exp_r = reports_due.pop_front();
                    if (got_r.speed !== exp_r.speed || got_r.period !== exp_r.period ||
                        got_r.heading !== exp_r.heading || got_r.pin !== exp_r.pin ||
                        got_r.pulses !== exp_r.pulses || got_r.pos0 !== exp_r.pos0 ||
                        got_r.pos1 !== exp_r.pos1)
                        note_failure("mismatch", exp_r, got_r);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_report(action, motor, rpm_target, exp_r);
                reports_due.push_back(exp_r);
            end
            pending = reports_due.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives speed and tick words into the step generator through several
// register settings, with random gaps and report stalls; the checker
// predicts every report word and counts failures.
// ----------------------------------------------------------------------------
module testbench;
    import srsg_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       action;
    logic                       motor;
    logic signed [SPEED_W-1:0]  rpm_target;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SPEED_W-1:0]  ramped_speed;
    logic [OUT_PER_W-1:0]       compare_period;
    logic [DIR_W-1:0]           motion_dir;
    logic                       dir_pin;
    logic [PULSE_W-1:0]         step_pulses;
    logic signed [POS_W-1:0]    position_first;
    logic signed [POS_W-1:0]    position_second;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    int                         fail_count;
    int                         pending;
    logic                       jitter;

    stepper_ramp_step_generator_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .motor           (motor),
        .rpm_target      (rpm_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ramped_speed    (ramped_speed),
        .compare_period  (compare_period),
        .motion_dir      (motion_dir),
        .dir_pin         (dir_pin),
        .step_pulses     (step_pulses),
        .position_first  (position_first),
        .position_second (position_second),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    step_rate_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .motor           (motor),
        .rpm_target      (rpm_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ramped_speed    (ramped_speed),
        .compare_period  (compare_period),
        .motion_dir      (motion_dir),
        .dir_pin         (dir_pin),
        .step_pulses     (step_pulses),
        .position_first  (position_first),
        .position_second (position_second),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("testbench NOT OK");
        $finish;
    end

    // report side: random stall bursts while jitter is on
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (jitter && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    task automatic send_word(input logic act, input logic mot,
                             input logic signed [SPEED_W-1:0] tgt);
        if (jitter && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        motor      = mot;
        rpm_target = tgt;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic signed [SPEED_W-1:0] pick_target();
        logic signed [SPEED_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sh7FFF;
            1: v = -16'sh8000;
            2: v = '0;
            3, 4, 5: v = SPEED_W'($urandom_range(0, 600) - 300);
            default: v = SPEED_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    initial
    begin
        logic act;
        logic [ACCEL_W-1:0]    acc_v;
        logic [DIVIDEND_W-1:0] rpm_v;
        logic [ZSP_W-1:0]      zsp_v;
        in_valid   = 1'b0;
        action     = ACT_TICK;
        motor      = 1'b0;
        rpm_target = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_MAX_ACCEL;
        cfg_data   = '0;
        jitter     = 1'b1;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: ramp limit, direction pins, stopped motor
        send_word(ACT_TICK, 1'b0, 16'sh7FFF);
        send_word(ACT_TICK, 1'b1, -16'sh8000);
        send_word(ACT_SET,  1'b0, 16'sh7FFF);
        send_word(ACT_SET,  1'b1, -16'sh8000);
        send_word(ACT_SET,  1'b1, -16'sh8000);
        send_word(ACT_SET,  1'b0, 16'sh0000);
        send_word(ACT_SET,  1'b0, -16'sd3);
        send_word(ACT_SET,  1'b0, 16'sd5);
        send_word(ACT_TICK, 1'b0, 16'sh1234);

        // zero quotient: match on every tick, counter restart on motor 1
        drain();
        write_reg(REG_RPM_TO_PERIOD, 32'd0);
        send_word(ACT_SET,  1'b0, 16'sd7);
        send_word(ACT_TICK, 1'b0, 16'sh0000);
        send_word(ACT_TICK, 1'b1, 16'shFFFF);
        send_word(ACT_TICK, 1'b0, 16'sh5A5A);
        send_word(ACT_SET,  1'b1, -16'sd16);
        send_word(ACT_TICK, 1'b1, 16'shA5A5);

        // quotient above period range
        drain();
        write_reg(REG_RPM_TO_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_ZERO_SPEED, 32'h0000_1234);
        send_word(ACT_SET,  1'b0, 16'sd7);
        send_word(ACT_SET,  1'b0, 16'sh7FFF);
        send_word(ACT_TICK, 1'b0, 16'sh0000);
        drain();
        write_reg(REG_MAX_ACCEL, 32'd32767);
        send_word(ACT_SET,  1'b1, 16'sh7FFF);
        send_word(ACT_SET,  1'b0, -16'sh8000);
        send_word(ACT_TICK, 1'b1, 16'sh0000);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    acc_v = 15'h7FFF;
                    rpm_v = 32'hFFFF_FFFF;
                    zsp_v = 16'h0000;
                end
                1:
                begin
                    acc_v = 15'h0000;
                    rpm_v = 32'h0000_0000;
                    zsp_v = 16'hFFFF;
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: acc_v = ACCEL_W'($urandom_range(1, 16));
                        1: acc_v = ACCEL_W'($urandom_range(0, 32767));
                        default: acc_v = ACCEL_W'($urandom_range(100, 2000));
                    endcase
                    case ($urandom_range(0, 2))
                        0: rpm_v = $urandom_range(0, 3000);
                        1: rpm_v = $urandom;
                        default: rpm_v = $urandom_range(20000, 2000000);
                    endcase
                    if ($urandom_range(0, 1) == 0)
                        zsp_v = ZSP_W'($urandom_range(0, 40));
                    else
                        zsp_v = ZSP_W'($urandom_range(0, 65535));
                end
            endcase
            write_reg(REG_MAX_ACCEL, {17'd0, acc_v});
            write_reg(REG_RPM_TO_PERIOD, rpm_v);
            write_reg(REG_ZERO_SPEED, {16'd0, zsp_v});
            for (int i = 0; i < 240; i++)
            begin
                jitter = (ph < 5) && ((i / 60) % 3 != 2);
                act = ($urandom_range(0, 9) < 7) ? ACT_TICK : ACT_SET;
                send_word(act, 1'($urandom_range(0, 1)), pick_target());
            end
        end

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/srsg_pkg.sv
hdl/srsg_div.sv
hdl/srsg_motors.sv
hdl/stepper_ramp_step_generator_core.sv
hdl/srsg_checker.sv
tb/step_rate_checker.sv
tb/testbench.sv
